// File: sv/gdr_pkg.sv
`timescale 1ns / 1ps

package gdr_pkg;

  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;
  localparam logic [15:0] LH_MAX   = 16'hFFFF;
  localparam logic [16:0] FRAC_ONE = 17'h10000;
  localparam int          CAM_OFS  = 16384;

  typedef enum logic [2:0] {
    CFG_PLAYER_X = 3'd0,
    CFG_PLAYER_Y = 3'd1,
    CFG_DIR_X    = 3'd2,
    CFG_DIR_Y    = 3'd3,
    CFG_PLANE_X  = 3'd4,
    CFG_PLANE_Y  = 3'd5,
    CFG_MAP_W    = 3'd6,
    CFG_MAP_H    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_SKIP  = 2'd1,
    OP_CAST  = 2'd2
  } op_e;

  typedef struct packed {
    logic       kind;
    logic [9:0] column;
    logic [5:0] cell_col;
    logic [5:0] cell_row;
    logic       cell_wall;
  } in_t;

  typedef struct packed {
    logic [8:0]         draw_start;
    logic [8:0]         draw_end;
    logic [15:0]        line_height;
    logic [23:0]        wall_distance;
    logic signed [7:0]  hit_col;
    logic signed [7:0]  hit_row;
    logic               hit_side;
  } out_t;

  typedef struct packed {
    op_e        op;
    logic [9:0] column;
    logic [5:0] cell_col;
    logic [5:0] cell_row;
    logic       cell_wall;
  } cmd_t;

  typedef struct packed {
    logic [21:0]        player_x;
    logic [21:0]        player_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
    logic [6:0]         map_w;
    logic [6:0]         map_h;
  } cfg_t;

endpackage

// File: sv/grid_dda_raycaster_unit.sv
`timescale 1ns / 1ps
// Grid DDA ray caster.
// Input queue: drive in_i and push while full is low. kind 0 writes one map
// cell (no result), kind 1 casts a ray for a screen column (one result).
// Result queue: while empty is low the oldest result is on out_o; pop takes it.
// Config: cfg_valid_i with cfg_index_i/cfg_data_i writes one register; ready
// is always high. Write config only while the block is idle.
// Requests pass a two-entry queue to the back end, which owns the wall map
// and a shared restoring divider.
// A cast runs setup and divisions for the step distances and line height,
// plus a map lookup for each crossed cell of the walk.
// After reset the map is cleared one cell a cycle, all MAP_SIDE * MAP_SIDE
// cells, with full held high. Register reset values apply at once.
// When the receiver stalls, the finished result is held and the back end
// waits before presenting the next one; the input queue keeps taking
// requests until it fills.

module grid_dda_raycaster_unit import gdr_pkg::*; #(
  parameter int SCREEN_W = 640,
  parameter int SCREEN_H = 480,
  parameter int MAP_SIDE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_t         in_i,
  output logic        empty,
  input  logic        pop,
  output out_t        out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [21:0] cfg_data_i
);

  logic clearing;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  gdr_front #(.MAP_SIDE(MAP_SIDE)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .clearing_i  (clearing),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  gdr_back #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H),
    .MAP_SIDE (MAP_SIDE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .clearing_o  (clearing),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o)
  );

endmodule

// File: sv/gdr_div.sv
`timescale 1ns / 1ps

module gdr_div #(
  parameter int DVW = 31,
  parameter int DSW = 29
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [DSW-1:0] divisor_i,
  output logic           busy_o,
  output logic           done_o,
  output logic [DVW-1:0] quotient_o
);

  localparam int CNTW = $clog2(DVW + 1);

  logic [DVW-1:0]  quo_q;
  logic [DSW-1:0]  rem_q;
  logic [DSW-1:0]  dsr_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [DSW:0]    rem_sh;
  logic [DSW+1:0]  diff;

  assign rem_sh = {rem_q, quo_q[DVW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(DVW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[DSW+1]) begin
        rem_q <= diff[DSW-1:0];
      end else begin
        rem_q <= rem_sh[DSW-1:0];
      end
      quo_q <= {quo_q[DVW-2:0], ~diff[DSW+1]};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: sv/gdr_front.sv
`timescale 1ns / 1ps

module gdr_front import gdr_pkg::*; #(
  parameter int MAP_SIDE = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  in_t  in_i,
  input  logic clearing_i,
  output logic cmd_valid_o,
  output cmd_t cmd_o,
  input  logic cmd_pop_i
);

  cmd_t       buf_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;
  cmd_t       cmd_new;

  always_comb begin
    cmd_new.column    = in_i.column;
    cmd_new.cell_col  = in_i.cell_col;
    cmd_new.cell_row  = in_i.cell_row;
    cmd_new.cell_wall = in_i.cell_wall;
    if (in_i.kind) begin
      cmd_new.op = OP_CAST;
    end else if ((32'(in_i.cell_col) >= MAP_SIDE) || (32'(in_i.cell_row) >= MAP_SIDE)) begin
      cmd_new.op = OP_SKIP;
    end else begin
      cmd_new.op = OP_WRITE;
    end
  end

  assign full        = (cnt_q == 2'd2) || clearing_i;
  assign do_push     = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign do_pop      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// File: sv/gdr_back.sv
`timescale 1ns / 1ps

module gdr_back import gdr_pkg::*; #(
  parameter int SCREEN_W = 640,
  parameter int SCREEN_H = 480,
  parameter int MAP_SIDE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [21:0] cfg_data_i,
  output logic        clearing_o,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output logic        empty,
  input  logic        pop,
  output out_t        out_o
);

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAP_SIDE);
  localparam int CW    = ((RW > 7) ? RW : 7) + 2;
  localparam int CAMW  = 26;
  localparam int PW    = 16 + CAMW;
  localparam int RXW   = PW - 13;
  localparam int DVW   = 31;
  localparam int DSW   = RXW;
  localparam int SIDEW = 26 + $clog2(MAP_SIDE + 2);
  localparam int HALF  = SCREEN_H / 2;
  localparam int CAM_SH = 22;
  localparam logic [36:0] CAM_RCP =
    37'(((64'd1 << 37) + 64'(SCREEN_W) - 64'd1) / 64'(SCREEN_W));

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CAM, S_RAYX, S_RAYY, S_DX, S_DY, S_SIDEX, S_SIDEY,
    S_STEP, S_LOOK, S_CHECK, S_DIST, S_LH, S_DRAW
  } state_e;

  state_e                  state_q;
  cfg_t                    cfg_q;
  logic [AW-1:0]           clr_q;
  logic [9:0]              column_q;
  logic signed [CAMW-1:0]  cam_q;
  logic signed [RXW-1:0]   rx_q, ry_q;
  logic [23:0]             dx_q, dy_q;
  logic [SIDEW-1:0]        side_x_q, side_y_q;
  logic signed [CW-1:0]    mx_q, my_q;
  logic                    side_q;
  logic [AW-1:0]           addr_q;
  logic [23:0]             dist_q;
  logic [15:0]             lh_q;
  out_t                    out_q;
  logic                    out_valid_q;
  logic                    div_start_q;
  logic [DVW-1:0]          div_dvd_q;
  logic [DSW-1:0]          div_dsr_q;
  logic                    div_busy, div_done;
  logic [DVW-1:0]          div_quo;

  logic                    wall_map [DEPTH];
  logic                    mem_rd_q;
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  logic                    mem_wd;

  logic [46:0]             cam_prod;
  logic signed [PW-1:0]    prod_x, prod_y;
  logic [RXW-1:0]          abs_rx, abs_ry;
  logic [23:0]             delta_sat;
  logic [40:0]             prod_sx, prod_sy;
  logic [16:0]             frac_x, frac_y;
  logic signed [CW-1:0]    w_c, h_c, mx_n, my_n;
  logic [SIDEW-1:0]        sx_n, sy_n, dist_w;
  logic                    step_x, outside;
  logic [23:0]             dist_c;
  logic signed [17:0]      ds_c, de_c;

  assign clearing_o = (state_q == S_CLEAR);
  assign cmd_pop_o  = (state_q == S_IDLE) && cmd_valid_i;
  assign empty      = !out_valid_q;
  assign out_o      = out_q;

  assign mem_we = (state_q == S_CLEAR) || (cmd_pop_o && (cmd_i.op == OP_WRITE));
  assign mem_wa = (state_q == S_CLEAR) ? clr_q :
                  AW'(32'(cmd_i.cell_row) * MAP_SIDE + 32'(cmd_i.cell_col));
  assign mem_wd = (state_q == S_CLEAR) ? 1'b0 : cmd_i.cell_wall;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wall_map[mem_wa] <= mem_wd;
    end
    mem_rd_q <= wall_map[addr_q];
  end

  gdr_div #(.DVW(DVW), .DSW(DSW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dvd_q),
    .divisor_i  (div_dsr_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign cam_prod  = 47'(column_q) * 47'(CAM_RCP);
  assign prod_x    = PW'(cfg_q.plane_x) * PW'(cam_q);
  assign prod_y    = PW'(cfg_q.plane_y) * PW'(cam_q);
  assign abs_rx    = rx_q[RXW-1] ? RXW'(-rx_q) : RXW'(rx_q);
  assign abs_ry    = ry_q[RXW-1] ? RXW'(-ry_q) : RXW'(ry_q);
  assign delta_sat = (div_quo > DVW'(DIST_MAX)) ? DIST_MAX : div_quo[23:0];

  assign frac_x  = rx_q[RXW-1] ? {1'b0, cfg_q.player_x[15:0]} :
                                 FRAC_ONE - {1'b0, cfg_q.player_x[15:0]};
  assign frac_y  = ry_q[RXW-1] ? {1'b0, cfg_q.player_y[15:0]} :
                                 FRAC_ONE - {1'b0, cfg_q.player_y[15:0]};
  assign prod_sx = 41'(frac_x) * 41'(dx_q);
  assign prod_sy = 41'(frac_y) * 41'(dy_q);

  assign w_c    = (32'(cfg_q.map_w) > MAP_SIDE) ? CW'(MAP_SIDE) : CW'(cfg_q.map_w);
  assign h_c    = (32'(cfg_q.map_h) > MAP_SIDE) ? CW'(MAP_SIDE) : CW'(cfg_q.map_h);
  assign step_x = side_x_q < side_y_q;
  assign sx_n   = side_x_q + SIDEW'(dx_q);
  assign sy_n   = side_y_q + SIDEW'(dy_q);
  assign mx_n   = step_x ? (rx_q[RXW-1] ? mx_q - 1'b1 : mx_q + 1'b1) : mx_q;
  assign my_n   = step_x ? my_q : (ry_q[RXW-1] ? my_q - 1'b1 : my_q + 1'b1);
  assign outside = (mx_n < 0) || (mx_n >= w_c) || (my_n < 0) || (my_n >= h_c);

  assign dist_w = side_q ? side_y_q - SIDEW'(dy_q) : side_x_q - SIDEW'(dx_q);
  assign dist_c = (dist_w > SIDEW'(DIST_MAX)) ? DIST_MAX : dist_w[23:0];

  assign ds_c = 18'(HALF) - 18'(lh_q >> 1);
  assign de_c = 18'(HALF) + 18'(lh_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_q         <= '0;
      out_valid_q   <= 1'b0;
      div_start_q   <= 1'b0;
      cfg_q.player_x <= '0;
      cfg_q.player_y <= '0;
      cfg_q.dir_x    <= 16'sd16384;
      cfg_q.dir_y    <= '0;
      cfg_q.plane_x  <= '0;
      cfg_q.plane_y  <= 16'sd10813;
      cfg_q.map_w    <= 7'd64;
      cfg_q.map_h    <= 7'd64;
    end else begin
      div_start_q <= 1'b0;
      if (out_valid_q && pop) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_PLAYER_X: cfg_q.player_x <= cfg_data_i;
          CFG_PLAYER_Y: cfg_q.player_y <= cfg_data_i;
          CFG_DIR_X:    cfg_q.dir_x    <= cfg_data_i[15:0];
          CFG_DIR_Y:    cfg_q.dir_y    <= cfg_data_i[15:0];
          CFG_PLANE_X:  cfg_q.plane_x  <= cfg_data_i[15:0];
          CFG_PLANE_Y:  cfg_q.plane_y  <= cfg_data_i[15:0];
          CFG_MAP_W:    cfg_q.map_w    <= cfg_data_i[6:0];
          CFG_MAP_H:    cfg_q.map_h    <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid_i && (cmd_i.op == OP_CAST)) begin
            column_q <= cmd_i.column;
            state_q  <= S_CAM;
          end
        end
        S_CAM: begin
          cam_q   <= CAMW'(cam_prod >> CAM_SH) - CAMW'(CAM_OFS);
          state_q <= S_RAYX;
        end
        S_RAYX: begin
          rx_q    <= RXW'(PW'(cfg_q.dir_x) + (prod_x >>> 14));
          state_q <= S_RAYY;
        end
        S_RAYY: begin
          ry_q        <= RXW'(PW'(cfg_q.dir_y) + (prod_y >>> 14));
          div_dvd_q   <= DVW'(31'h40000000);
          div_dsr_q   <= (rx_q == 0) ? DSW'(1) : abs_rx;
          div_start_q <= 1'b1;
          state_q     <= S_DX;
        end
        S_DX: begin
          if (div_done) begin
            dx_q        <= (rx_q == 0) ? DIST_MAX : delta_sat;
            div_dvd_q   <= DVW'(31'h40000000);
            div_dsr_q   <= (ry_q == 0) ? DSW'(1) : abs_ry;
            div_start_q <= 1'b1;
            state_q     <= S_DY;
          end
        end
        S_DY: begin
          if (div_done) begin
            dy_q    <= (ry_q == 0) ? DIST_MAX : delta_sat;
            state_q <= S_SIDEX;
          end
        end
        S_SIDEX: begin
          side_x_q <= SIDEW'(prod_sx >> 16);
          mx_q     <= CW'(cfg_q.player_x[21:16]);
          my_q     <= CW'(cfg_q.player_y[21:16]);
          state_q  <= S_SIDEY;
        end
        S_SIDEY: begin
          side_y_q <= SIDEW'(prod_sy >> 16);
          state_q  <= S_STEP;
        end
        S_STEP: begin
          if (step_x) begin
            side_x_q <= sx_n;
          end else begin
            side_y_q <= sy_n;
          end
          side_q  <= !step_x;
          mx_q    <= mx_n;
          my_q    <= my_n;
          addr_q  <= AW'(32'($unsigned(my_n)) * MAP_SIDE + 32'($unsigned(mx_n)));
          state_q <= outside ? S_DIST : S_LOOK;
        end
        S_LOOK: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          state_q <= mem_rd_q ? S_DIST : S_STEP;
        end
        S_DIST: begin
          dist_q <= dist_c;
          if (dist_c == 24'd0) begin
            lh_q    <= LH_MAX;
            state_q <= S_DRAW;
          end else begin
            div_dvd_q   <= DVW'(32'(SCREEN_H) << 16);
            div_dsr_q   <= DSW'(dist_c);
            div_start_q <= 1'b1;
            state_q     <= S_LH;
          end
        end
        S_LH: begin
          if (div_done) begin
            lh_q    <= (div_quo > DVW'(LH_MAX)) ? LH_MAX : div_quo[15:0];
            state_q <= S_DRAW;
          end
        end
        S_DRAW: begin
          if (!out_valid_q) begin
            out_q.draw_start    <= ds_c[17] ? 9'd0 : ds_c[8:0];
            out_q.draw_end      <= (de_c >= 18'(SCREEN_H)) ? 9'(SCREEN_H - 1) : de_c[8:0];
            out_q.line_height   <= lh_q;
            out_q.wall_distance <= dist_q;
            out_q.hit_col       <= 8'(mx_q);
            out_q.hit_row       <= 8'(my_q);
            out_q.hit_side      <= side_q;
            out_valid_q         <= 1'b1;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |=> out_valid_q)
    else $error("result dropped while waiting");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> !div_busy)
    else $error("divider restarted while busy");

  a_clear_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !cmd_pop_o)
    else $error("request taken during clear");

  a_walk_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |-> !mem_we)
    else $error("map written during walk");

endmodule

// File: bench/grid_dda_raycaster_unit_tb.sv
`timescale 1ns / 1ps

module grid_dda_raycaster_unit_tb;
  import gdr_pkg::*;

  localparam int SCR_W = 640;
  localparam int SCR_H = 480;
  localparam int SIDE = 64;
  localparam longint CYCLE_LIMIT = 3000000;

  class raycast_scoreboard;
    logic [21:0]        pos_x, pos_y;
    logic signed [15:0] view_x, view_y, cam_x, cam_y;
    logic [6:0]         cols_used, rows_used;
    bit                 wall_map [SIDE*SIDE];
    out_t               expected_q [$];
    int                 errors;

    function new();
      pos_x = '0;
      pos_y = '0;
      view_x = 16'sd16384;
      view_y = '0;
      cam_x = '0;
      cam_y = 16'sd10813;
      cols_used = 7'd64;
      rows_used = 7'd64;
      foreach (wall_map[i]) wall_map[i] = 1'b0;
      errors = 0;
    endfunction

    function void note_config(cfg_idx_e idx, logic [21:0] d);
      case (idx)
        CFG_PLAYER_X: pos_x = d;
        CFG_PLAYER_Y: pos_y = d;
        CFG_DIR_X:    view_x = d[15:0];
        CFG_DIR_Y:    view_y = d[15:0];
        CFG_PLANE_X:  cam_x = d[15:0];
        CFG_PLANE_Y:  cam_y = d[15:0];
        CFG_MAP_W:    cols_used = d[6:0];
        CFG_MAP_H:    rows_used = d[6:0];
        default: ;
      endcase
    endfunction

    function longint unsigned step_dist(longint r);
      longint unsigned a, q;
      if (r == 0) return longint'(DIST_MAX);
      a = (r < 0) ? -r : r;
      q = (longint'(1) << 30) / a;
      return (q > longint'(DIST_MAX)) ? longint'(DIST_MAX) : q;
    endfunction

    function void note_request(in_t r);
      longint cam, rx, ry, mx, my, sx, sy, w, h, lh, ds, de;
      longint unsigned dx, dy, fx, fy, side_x, side_y, wall_dist;
      bit side;
      out_t e;
      if (r.kind == 1'b0) begin
        wall_map[r.cell_row * SIDE + r.cell_col] = r.cell_wall;
        return;
      end
      side = 1'b0;
      cam = longint'((longint'(r.column) << 15) / SCR_W) - 16384;
      rx = longint'(view_x) + ((longint'(cam_x) * cam) >>> 14);
      ry = longint'(view_y) + ((longint'(cam_y) * cam) >>> 14);
      dx = step_dist(rx);
      dy = step_dist(ry);
      mx = longint'(pos_x >> 16);
      my = longint'(pos_y >> 16);
      fx = 64'(pos_x[15:0]);
      fy = 64'(pos_y[15:0]);
      sx = (rx < 0) ? -1 : 1;
      sy = (ry < 0) ? -1 : 1;
      side_x = (((rx < 0) ? fx : 65536 - fx) * dx) >> 16;
      side_y = (((ry < 0) ? fy : 65536 - fy) * dy) >> 16;
      w = (cols_used > SIDE) ? 64'(SIDE) : 64'(cols_used);
      h = (rows_used > SIDE) ? 64'(SIDE) : 64'(rows_used);
      forever begin
        if (side_x < side_y) begin
          side_x += dx;
          mx += sx;
          side = 1'b0;
        end else begin
          side_y += dy;
          my += sy;
          side = 1'b1;
        end
        if (mx < 0 || mx >= w || my < 0 || my >= h) break;
        if (wall_map[my * SIDE + mx]) break;
      end
      wall_dist = side ? side_y - dy : side_x - dx;
      if (wall_dist > longint'(DIST_MAX)) wall_dist = longint'(DIST_MAX);
      if (wall_dist == 0) lh = 65535;
      else begin
        lh = (longint'(SCR_H) << 16) / wall_dist;
        if (lh > 65535) lh = 65535;
      end
      ds = SCR_H / 2 - lh / 2;
      if (ds < 0) ds = 0;
      de = SCR_H / 2 + lh / 2;
      if (de >= SCR_H) de = SCR_H - 1;
      e.draw_start = ds[8:0];
      e.draw_end = de[8:0];
      e.line_height = lh[15:0];
      e.wall_distance = wall_dist[23:0];
      e.hit_col = mx[7:0];
      e.hit_row = my[7:0];
      e.hit_side = side;
      expected_q.push_back(e);
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.draw_start !== e.draw_start) begin
        $error("draw_start expected %0d actual %0d", e.draw_start, got.draw_start);
        errors++;
      end
      if (got.draw_end !== e.draw_end) begin
        $error("draw_end expected %0d actual %0d", e.draw_end, got.draw_end);
        errors++;
      end
      if (got.line_height !== e.line_height) begin
        $error("line_height expected %0d actual %0d", e.line_height, got.line_height);
        errors++;
      end
      if (got.wall_distance !== e.wall_distance) begin
        $error("wall_distance expected %0h actual %0h", e.wall_distance,
               got.wall_distance);
        errors++;
      end
      if (got.hit_col !== e.hit_col) begin
        $error("hit_col expected %0d actual %0d", e.hit_col, got.hit_col);
        errors++;
      end
      if (got.hit_row !== e.hit_row) begin
        $error("hit_row expected %0d actual %0d", e.hit_row, got.hit_row);
        errors++;
      end
      if (got.hit_side !== e.hit_side) begin
        $error("hit_side expected %0d actual %0d", e.hit_side, got.hit_side);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        push, full, empty, pop;
  in_t         in_i;
  out_t        out_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [21:0] cfg_data_i;

  raycast_scoreboard sb;
  int send_idle_pct, pop_stall_pct;
  longint cycles;

  grid_dda_raycaster_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full), .in_i(in_i),
    .empty(empty), .pop(pop), .out_o(out_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_result(out_o);
  end

  always @(negedge clk_i) begin
    if (!rst_ni) pop = 1'b0;
    else pop = ($urandom_range(99) >= pop_stall_pct);
  end

  task automatic cfg_write(cfg_idx_e idx, logic [21:0] d);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(idx, d);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic send_request(in_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push = 1'b1;
    in_i = r;
    do @(posedge clk_i); while (full);
    sb.note_request(r);
    @(negedge clk_i);
    push = 1'b0;
  endtask

  task automatic cast_column(logic [9:0] col);
    in_t r;
    r = '0;
    r.kind = 1'b1;
    r.column = col;
    r.cell_col = 6'($urandom);
    r.cell_row = 6'($urandom);
    r.cell_wall = 1'($urandom);
    send_request(r);
  endtask

  task automatic write_cell(logic [5:0] c, logic [5:0] row, logic wall);
    in_t r;
    r.kind = 1'b0;
    r.column = 10'($urandom);
    r.cell_col = c;
    r.cell_row = row;
    r.cell_wall = wall;
    send_request(r);
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_config(int style);
    logic [6:0] w, h;
    w = 7'($urandom_range(1, 64));
    h = 7'($urandom_range(1, 64));
    if (style == 1) begin
      w = 7'd127;
      h = 7'd1;
    end else if (style == 2) begin
      w = 7'd0;
      h = 7'd64;
    end
    cfg_write(CFG_MAP_W, 22'(w));
    cfg_write(CFG_MAP_H, 22'(h));
    if ($urandom_range(3) == 0) begin
      cfg_write(CFG_PLAYER_X, 22'($urandom_range(22'h3FFFFF)));
      cfg_write(CFG_PLAYER_Y, 22'($urandom_range(22'h3FFFFF)));
    end else begin
      cfg_write(CFG_PLAYER_X, 22'($urandom_range((w > 64 ? 64 : w) * 65536 - 1)));
      cfg_write(CFG_PLAYER_Y, 22'($urandom_range((h > 64 ? 64 : h) * 65536 - 1)));
    end
    cfg_write(CFG_DIR_X, 22'($urandom));
    cfg_write(CFG_DIR_Y, 22'($urandom));
    cfg_write(CFG_PLANE_X, 22'($urandom));
    cfg_write(CFG_PLANE_Y, 22'($urandom));
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_PLAYER_X;
    cfg_data_i = '0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    cast_column(10'd320);
    drain();
    cfg_write(CFG_PLAYER_X, 22'h28000);
    cfg_write(CFG_PLAYER_Y, 22'h28000);
    write_cell(6'd5, 6'd2, 1'b1);
    write_cell(6'd63, 6'd63, 1'b1);
    write_cell(6'd0, 6'd0, 1'b0);
    cast_column(10'd0);
    cast_column(10'd320);
    cast_column(10'd639);
    cast_column(10'd1023);
    drain();
    cfg_write(CFG_PLAYER_X, 22'h30000);
    cfg_write(CFG_DIR_X, 22'h38000);
    cfg_write(CFG_DIR_Y, 22'h0);
    cfg_write(CFG_PLANE_X, 22'h0);
    cfg_write(CFG_PLANE_Y, 22'h7FFF);
    cast_column(10'd320);
    cast_column(10'd0);
    drain();
    cfg_write(CFG_PLAYER_X, 22'h3FFFFF);
    cfg_write(CFG_PLAYER_Y, 22'h0);
    cfg_write(CFG_DIR_X, 22'h7FFF);
    cfg_write(CFG_DIR_Y, 22'h8000);
    cast_column(10'd100);
    cast_column(10'd600);
    drain();
    cfg_write(CFG_PLAYER_X, 22'h8000);
    cfg_write(CFG_MAP_W, 22'd0);
    cast_column(10'd320);
    drain();
    cfg_write(CFG_MAP_W, 22'd127);
    cfg_write(CFG_MAP_H, 22'd1);
    cast_column(10'd511);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 72; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 72; end
        default: begin send_idle_pct = 33; pop_stall_pct = 33; end
      endcase
      random_config(phase == 3 ? 1 : (phase == 6 ? 2 : 0));
      for (int n = 0; n < 92; n++) begin
        if ($urandom_range(99) < 40)
          write_cell(6'($urandom), 6'($urandom), $urandom_range(99) < 30);
        else
          cast_column(10'($urandom));
        if (phase == 5 && n == 46) drain();
      end
      drain();
    end

    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: grid_dda_raycaster_unit.f
sv/gdr_pkg.sv
sv/gdr_div.sv
sv/gdr_front.sv
sv/gdr_back.sv
sv/grid_dda_raycaster_unit.sv
bench/grid_dda_raycaster_unit_tb.sv
